// ===== rtl/jfc_pkg.sv =====
// Shared constants, types and the jet color function for the jet false color mapper.
package jfc_pkg;

  localparam int PIXEL_BITS_DEF   = 16;
  localparam int COLOR_LEVELS_DEF = 128;
  localparam int PIX_IN_W         = 16;
  localparam int RANGE_W          = 16;
  localparam int DISP_SHIFT       = 6;
  localparam int IDX_OUT_W        = 7;
  localparam int BYTE_W           = 8;
  localparam int CFG_IDX_W        = 2;
  localparam int JET_STEPS        = 128;

  localparam logic [1:0] OP_MEASURE = 2'd0;
  localparam logic [1:0] OP_MAP     = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_DISP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_COLOR
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] r;
  } color_t;

  // floor(255 * k / 32), k in 0..32
  function automatic logic [BYTE_W-1:0] level_byte(logic [5:0] k);
    logic [13:0] p;
    p = 14'(k) * 14'd255;
    return p[12:5];
  endfunction

  function automatic color_t jet_color(logic [6:0] t);
    logic [5:0] rk;
    logic [5:0] gk;
    logic [5:0] bk;
    color_t     c;
    if (t < 7'd16) begin
      rk = 6'd0;
      gk = 6'd0;
      bk = 6'(7'd17 + t);
    end else if (t < 7'd48) begin
      rk = 6'd0;
      gk = 6'(t - 7'd15);
      bk = 6'd32;
    end else if (t < 7'd80) begin
      rk = 6'(t - 7'd47);
      gk = 6'd32;
      bk = 6'(7'd79 - t);
    end else if (t < 7'd112) begin
      rk = 6'd32;
      gk = 6'(7'd111 - t);
      bk = 6'd0;
    end else begin
      rk = 6'(8'd143 - {1'b0, t});
      gk = 6'd0;
      bk = 6'd0;
    end
    c.b = level_byte(bk);
    c.g = level_byte(gk);
    c.r = level_byte(rk);
    return c;
  endfunction

endpackage

// ===== rtl/jfc_ifs.sv =====
// Valid/ready channel interfaces: pixel input, color output and register writes.
interface jfc_in_if import jfc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [PIX_IN_W-1:0] pixel;
  modport source (output valid, output op, output pixel, input ready);
  modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface jfc_out_if import jfc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    blue;
  logic [BYTE_W-1:0]    green;
  logic [BYTE_W-1:0]    red;
  logic [IDX_OUT_W-1:0] color_index;
  modport source (output valid, output blue, output green, output red,
                  output color_index, input ready);
  modport sink   (input valid, input blue, input green, input red,
                  input color_index, output ready);
endinterface

interface jfc_cfg_if import jfc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RANGE_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/jet_false_color_mapper_top.sv =====
// Flow: a map goes through capture, multiply, restoring divide and color lookup; zero pixels,
//   values at or below the low bound, or an empty range skip the divider and go to lookup.
// Input is ready only when idle, so a new pixel waits until the last item is done; the
//   restoring divider retires one quotient bit per cycle.
// Reset: clears control, registers and the measured range (min all ones, max zero).
// Register writes are always ready and take effect on the next cycle.
module jet_false_color_mapper_top import jfc_pkg::*; #(
  parameter int PIXEL_BITS   = PIXEL_BITS_DEF,
  parameter int COLOR_LEVELS = COLOR_LEVELS_DEF
) (
  input logic        clk,
  input logic        rst,
  jfc_in_if.sink     pixels,
  jfc_out_if.source  colors,
  jfc_cfg_if.sink    cfg
);

  localparam int IDX_W  = $clog2(COLOR_LEVELS);
  localparam int CNT_W  = $clog2(IDX_W);
  localparam int PROD_W = PIXEL_BITS + IDX_W;

  state_t state, state_next;

  logic [RANGE_W-1:0]    range_low;
  logic [RANGE_W-1:0]    range_high;
  logic                  input_is_disp;
  logic [PIXEL_BITS-1:0] meas_min;
  logic [PIXEL_BITS-1:0] meas_max;

  logic [1:0]            op_q;
  logic [PIXEL_BITS-1:0] value;
  logic [RANGE_W-1:0]    span;
  logic [PIXEL_BITS-1:0] num;
  logic [RANGE_W-1:0]    rem;
  logic [IDX_W-1:0]      dlow;
  logic [IDX_W-1:0]      quot;
  logic [CNT_W-1:0]      cnt;

  logic                  out_valid;
  color_t                out_color;
  logic [IDX_OUT_W-1:0]  out_index;

  logic [PIXEL_BITS-1:0] pix_raw;
  logic [PIXEL_BITS-1:0] pix_val;
  logic                  accept;
  logic                  load_out;

  logic [RANGE_W-1:0]    lo;
  logic [RANGE_W-1:0]    hi;
  logic [RANGE_W-1:0]    value_ext;
  logic [RANGE_W-1:0]    diff;
  logic [RANGE_W-1:0]    span_c;
  logic                  map_ok;
  logic [PROD_W-1:0]     prod;
  logic [RANGE_W:0]      shifted;
  logic                  ge;

  color_t                lut [COLOR_LEVELS];

  for (genvar gi = 0; gi < COLOR_LEVELS; gi++) begin : g_lut
    assign lut[gi] = jet_color(7'(gi * JET_STEPS / COLOR_LEVELS));
  end

  assign pix_raw = pixels.pixel[PIXEL_BITS-1:0];
  assign pix_val = input_is_disp ? (pix_raw >> DISP_SHIFT) : pix_raw;
  assign accept  = pixels.valid && pixels.ready;

  assign pixels.ready      = (state == ST_IDLE);
  assign cfg.ready         = 1'b1;
  assign colors.valid      = out_valid;
  assign colors.blue       = out_color.b;
  assign colors.green      = out_color.g;
  assign colors.red        = out_color.r;
  assign colors.color_index = out_index;

  // range select and clamp
  assign lo        = (range_high == '0) ? RANGE_W'(meas_min) : range_low;
  assign hi        = (range_high == '0) ? RANGE_W'(meas_max) : range_high;
  assign value_ext = RANGE_W'(value);
  assign diff      = value_ext - lo;
  assign span_c    = hi - lo;
  assign map_ok    = (value != '0) && (hi > lo) && (value_ext > lo);

  assign prod    = PROD_W'(num) * PROD_W'(COLOR_LEVELS - 1);
  assign shifted = {rem, dlow[IDX_W-1]};
  assign ge      = shifted >= {1'b0, span};

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_q == OP_MAP && map_ok) state_next = ST_MUL;
        else if (op_q == OP_MAP) state_next = ST_COLOR;
        else state_next = ST_IDLE;
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == '0) state_next = ST_COLOR;
      end
      ST_COLOR: begin
        if (!out_valid || colors.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low     <= '0;
      range_high    <= '0;
      input_is_disp <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_RANGE_LOW:  range_low     <= cfg.data;
        REG_RANGE_HIGH: range_high    <= cfg.data;
        REG_INPUT_DISP: input_is_disp <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_min <= '1;
      meas_max <= '0;
    end else if (state == ST_EXEC) begin
      if (op_q == OP_MEASURE) begin
        if (value < meas_min) meas_min <= value;
        if (value > meas_max) meas_max <= value;
      end else if (op_q == OP_CLEAR) begin
        meas_min <= '1;
        meas_max <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (colors.ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath: capture, clamp, multiply, restoring divide, color lookup
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= pixels.op;
      value <= pix_val;
    end
    unique case (state)
      ST_EXEC: begin
        span <= span_c;
        num  <= PIXEL_BITS'((diff > span_c) ? span_c : diff);
        quot <= '0;
      end
      ST_MUL: begin
        rem  <= RANGE_W'(prod[PROD_W-1:IDX_W]);
        dlow <= prod[IDX_W-1:0];
        cnt  <= CNT_W'(IDX_W - 1);
      end
      ST_DIV: begin
        rem  <= ge ? RANGE_W'(shifted - {1'b0, span}) : shifted[RANGE_W-1:0];
        dlow <= dlow << 1;
        quot <= {quot[IDX_W-2:0], ge};
        cnt  <= cnt - CNT_W'(1);
      end
      default: ;
    endcase
    if (load_out) begin
      out_color <= lut[quot];
      out_index <= IDX_OUT_W'(quot);
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> !pixels.ready)
    else $error("input ready right after a transfer");

  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < span))
    else $error("divider remainder not below span");

  a_clear_restores: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && op_q == OP_CLEAR) |=> (meas_min == '1 && meas_max == '0))
    else $error("clear did not restore measured range");

  a_color_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COLOR && !out_valid) |=> (colors.valid && pixels.ready))
    else $error("result not registered from color stage");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COLOR) |-> (32'(quot) < COLOR_LEVELS))
    else $error("color index beyond table");
`endif

endmodule

// ===== sim/tb_jet_false_color_mapper_top.sv =====
// Self-checking testbench for the jet false color mapper: directed and random pixel traffic.
`timescale 1ns / 100ps

module tb_jet_false_color_mapper_top;
  import jfc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 120;
  localparam int RANDOM_PHASES = 12;

  typedef struct packed {
    logic [BYTE_W-1:0]    blue;
    logic [BYTE_W-1:0]    green;
    logic [BYTE_W-1:0]    red;
    logic [IDX_OUT_W-1:0] color_index;
  } jet_color_t;

  class jet_scoreboard;
    logic [RANGE_W-1:0] range_lo;
    logic [RANGE_W-1:0] range_hi;
    logic               disp_mode;
    logic [RANGE_W-1:0] seen_min;
    logic [RANGE_W-1:0] seen_max;
    jet_color_t         expected_colors[$];
    int errors;
    int maps;
    int measures;
    int clears;
    int checked;

    function new();
      range_lo  = '0;
      range_hi  = '0;
      disp_mode = 1'b0;
      seen_min  = '1;
      seen_max  = '0;
      errors    = 0;
      maps      = 0;
      measures  = 0;
      clears    = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RANGE_W-1:0] data);
      case (idx)
        REG_RANGE_LOW: range_lo = data;
        REG_RANGE_HIGH: range_hi = data;
        REG_INPUT_DISP: disp_mode = data[0];
        default: ;
      endcase
    endfunction

    // channel level in 32nds: the lower of a rising and a falling ramp, clipped
    function int jet_level(int rise, int fall);
      int k;
      k = (rise < fall) ? rise : fall;
      if (k < 0) k = 0;
      if (k > 32) k = 32;
      return k;
    endfunction

    function logic [BYTE_W-1:0] level_to_byte(int k);
      int p;
      p = (255 * k) >>> 5;
      return p[BYTE_W-1:0];
    endfunction

    function void note_input(logic [1:0] op, logic [PIX_IN_W-1:0] pix);
      logic [RANGE_W-1:0] v;
      logic [RANGE_W-1:0] lo;
      logic [RANGE_W-1:0] hi;
      int span;
      int num;
      int idx;
      jet_color_t c;
      v = disp_mode ? (pix >> DISP_SHIFT) : pix;
      case (op)
        OP_MEASURE: begin
          measures++;
          if (v < seen_min) seen_min = v;
          if (v > seen_max) seen_max = v;
        end
        OP_CLEAR: begin
          clears++;
          seen_min = '1;
          seen_max = '0;
        end
        OP_MAP: begin
          maps++;
          if (range_hi == '0) begin
            lo = seen_min;
            hi = seen_max;
          end else begin
            lo = range_lo;
            hi = range_hi;
          end
          idx = 0;
          if (v != '0 && hi > lo && v > lo) begin
            span = int'(hi) - int'(lo);
            num = int'(v) - int'(lo);
            if (num > span) num = span;
            idx = ((COLOR_LEVELS_DEF - 1) * num) / span;
          end
          c.blue        = level_to_byte(jet_level(idx + 17, 79 - idx));
          c.green       = level_to_byte(jet_level(idx - 15, 111 - idx));
          c.red         = level_to_byte(jet_level(idx - 47, 143 - idx));
          c.color_index = idx[IDX_OUT_W-1:0];
          expected_colors.push_back(c);
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction

    function void check_result(jet_color_t got);
      jet_color_t want;
      if (expected_colors.size() == 0) begin
        $error("color transfer with nothing expected: b=%0d g=%0d r=%0d idx=%0d",
               got.blue, got.green, got.red, got.color_index);
        errors++;
        return;
      end
      want = expected_colors.pop_front();
      checked++;
      if (got.blue !== want.blue) begin
        $error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green mismatch: expected %0d, actual %0d", want.green, got.green);
        errors++;
      end
      if (got.red !== want.red) begin
        $error("red mismatch: expected %0d, actual %0d", want.red, got.red);
        errors++;
      end
      if (got.color_index !== want.color_index) begin
        $error("color_index mismatch: expected %0d, actual %0d",
               want.color_index, got.color_index);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_out;
  int   sent;
  int   settings_used;
  int   src_run;
  int   snk_run;
  jet_scoreboard sb;

  jfc_in_if  pixels_if();
  jfc_out_if colors_if();
  jfc_cfg_if cfg_if();

  jet_false_color_mapper_top dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels_if),
    .colors (colors_if),
    .cfg    (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // zero throughout a run, else 0..13; a new run starts now and then
  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      run_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic int value_max();
    return sb.disp_mode ? (65535 >> DISP_SHIFT) : 65535;
  endfunction

  function automatic logic [PIX_IN_W-1:0] to_pixel(int v);
    logic [PIX_IN_W-1:0] p;
    p = v[PIX_IN_W-1:0];
    if (sb.disp_mode) p = (p << DISP_SHIFT) | PIX_IN_W'($urandom_range(0, 63));
    return p;
  endfunction

  function automatic int near_value(int a, int b, int vmax);
    int span;
    int v;
    span = (b > a) ? b - a : a - b;
    if (span < 4) span = 4;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = int'($urandom_range(0, vmax));
      2: v = a;
      3: v = b;
      4: v = vmax;
      default: v = ((a < b) ? a : b) - span / 4 + int'($urandom_range(0, span + span / 2));
    endcase
    if (v < 0) v = 0;
    if (v > vmax) v = vmax;
    return v;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [PIX_IN_W-1:0] pix);
    int gap;
    gap = draw_gap(src_run);
    if (gap > 0) begin
      pixels_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixels_if.valid <= 1'b1;
    pixels_if.op    <= op;
    pixels_if.pixel <= pix;
    do @(posedge clk); while (!pixels_if.ready);
    sb.note_input(op, pix);
    if (op != OP_UNUSED) sent++;
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), PIX_IN_W'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RANGE_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic write_settings(input int lo, input int hi, input logic disp);
    write_reg(REG_RANGE_LOW, lo[RANGE_W-1:0]);
    write_reg(REG_RANGE_HIGH, hi[RANGE_W-1:0]);
    write_reg(REG_INPUT_DISP, {15'($urandom), disp});
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic settle();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // clear, measure a band, then map around it; sometimes the clear is dropped
  task automatic run_frame();
    int vmax;
    int base;
    int spread;
    int n;
    vmax = value_max();
    if ($urandom_range(0, 7) != 0) send_item(OP_CLEAR, PIX_IN_W'($urandom));
    spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, vmax) : $urandom_range(1, vmax / 8);
    base = $urandom_range(0, vmax - spread);
    n = $urandom_range(1, 16);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) send_noise();
      send_item(OP_MEASURE, to_pixel($urandom_range(base, base + spread)));
    end
    n = $urandom_range(1, 12);
    repeat (n) send_item(OP_MAP, to_pixel(near_value(base, base + spread, vmax)));
  endtask

  task automatic run_single();
    int vmax;
    vmax = value_max();
    case ($urandom_range(0, 15))
      0: send_noise();
      1: send_item(OP_MEASURE, PIX_IN_W'($urandom));
      2: send_item(OP_CLEAR, PIX_IN_W'($urandom));
      default: send_item(OP_MAP, to_pixel(near_value(sb.range_lo, sb.range_hi, vmax)));
    endcase
  endtask

  task automatic run_phase(input int n);
    int goal;
    goal = sent + n;
    while (sent < goal) begin
      if (sb.range_hi == '0 || $urandom_range(0, 5) == 0) run_frame();
      else run_single();
    end
    pixels_if.valid <= 1'b0;
    settle();
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("jet_false_color_mapper_top test failed");
    $finish;
  end

  initial begin : color_sink
    int stall;
    jet_color_t got;
    colors_if.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && colors_if.valid && colors_if.ready) begin
        got.blue        = colors_if.blue;
        got.green       = colors_if.green;
        got.red         = colors_if.red;
        got.color_index = colors_if.color_index;
        sb.check_result(got);
        stall = draw_gap(snk_run);
      end
      if (hold_out || stall > 0) begin
        colors_if.ready <= 1'b0;
        if (!hold_out) stall--;
      end else begin
        colors_if.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off while pixels keep coming
  initial begin : back_pressure
    hold_out = 1'b0;
    do @(posedge clk); while (sent < 100);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin : stimulus
    int lo;
    int hi;
    logic disp;
    sb = new();
    sent = 0;
    settings_used = 0;
    src_run = 0;
    snk_run = 0;
    rst = 1'b1;
    pixels_if.valid = 1'b0;
    pixels_if.op    = OP_MEASURE;
    pixels_if.pixel = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_RANGE_LOW;
    cfg_if.data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: measured range, plain depth
    send_item(OP_MAP, 16'd500);
    send_item(OP_MEASURE, 16'd0);
    send_item(OP_MEASURE, 16'hFFFF);
    send_item(OP_MAP, 16'd0);
    send_item(OP_MAP, 16'hFFFF);
    send_item(OP_MAP, 16'h8000);
    send_item(OP_MAP, 16'd1);
    send_item(OP_CLEAR, 16'hFFFF);
    send_item(OP_MAP, 16'd300);
    send_item(OP_MEASURE, 16'd1000);
    send_item(OP_MEASURE, 16'd3000);
    send_item(OP_MAP, 16'd999);
    send_item(OP_MAP, 16'd1000);
    send_item(OP_MAP, 16'd2000);
    send_item(OP_MAP, 16'd3000);
    send_item(OP_MAP, 16'd5000);
    send_item(OP_UNUSED, 16'hFFFF);
    send_item(OP_MAP, 16'd2000);
    pixels_if.valid <= 1'b0;
    settle();
    write_settings(100, 100, 1'b0);
    send_item(OP_MAP, 16'd100);
    send_item(OP_MAP, 16'd50000);
    pixels_if.valid <= 1'b0;
    settle();
    write_settings(5000, 100, 1'b0);
    send_item(OP_MAP, 16'd3000);
    send_item(OP_MAP, 16'hFFFF);
    pixels_if.valid <= 1'b0;
    settle();
    write_settings(0, 65535, 1'b1);
    send_item(OP_MAP, 16'hFFFF);
    send_item(OP_MAP, 16'd64);
    send_item(OP_MEASURE, 16'd63);
    send_item(OP_MAP, 16'd0);
    pixels_if.valid <= 1'b0;
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin lo = 0; hi = 65535; disp = 1'b0; end
        1: begin lo = 0; hi = 0; disp = 1'b0; end
        2: begin lo = 0; hi = 1; disp = 1'b0; end
        3: begin lo = 65534; hi = 65535; disp = 1'b0; end
        4: begin lo = $urandom; hi = 0; disp = 1'b1; end
        5: begin
          lo = $urandom_range(0, 900);
          hi = $urandom_range(lo + 1, 1023);
          disp = 1'b1;
        end
        6: begin lo = 65535; hi = 65535; disp = 1'b0; end
        default: begin
          disp = 1'($urandom_range(0, 1));
          lo = $urandom_range(0, disp ? 1023 : 65535);
          case ($urandom_range(0, 2))
            0: hi = 0;
            1: hi = $urandom_range(lo, disp ? 1023 : 65535);
            default: hi = $urandom_range(0, 65535);
          endcase
        end
      endcase
      write_settings(lo, hi, disp);
      run_phase(PHASE_ITEMS);
    end

    settle();
    $display("Summary: %0d pixel transfers (%0d map, %0d measure, %0d clear), %0d settings",
             sent, sb.maps, sb.measures, sb.clears, settings_used);
    $display("Summary: %0d colors checked, one %0d-cycle output hold-off",
             sb.checked, HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("jet_false_color_mapper_top test passed");
    end else begin
      $display("jet_false_color_mapper_top test failed");
    end
    $finish;
  end

endmodule

// ===== jet_false_color_mapper_top.f =====
rtl/jfc_pkg.sv
rtl/jfc_ifs.sv
rtl/jet_false_color_mapper_top.sv
sim/tb_jet_false_color_mapper_top.sv
